### rtl/button_press_classifier_top_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the button press classifier
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpc assertion failed");

// next-cycle implication, disabled while reset is low
`define BPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpc assertion failed");

`endif

### rtl/bpc_pkg.sv
// ---------------------------------------------------------------------------
// bpc_pkg
// types, codes and reset values of the button press classifier
// ---------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int BTN_W        = 2;
    localparam int CNT_W        = 16;
    localparam int MS_W         = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int OP_W         = 3;
    localparam int PIN_W        = 4;
    localparam int EV_W         = 4;
    localparam int S_DATA_W     = 40;
    localparam int M_DATA_W     = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [CFG_W-1:0] RELEASE_RST   = 16'd3;
    localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd1;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd50;
    localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd100;

    typedef enum logic [OP_W-1:0] {
        OP_EDGE      = 3'd0,
        OP_TICK      = 3'd1,
        OP_CHK_SHORT = 3'd2,
        OP_CHK_LONG  = 3'd3,
        OP_CLR_ALL   = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_RELEASE   = 3'd1,
        CFG_SHORT_MIN = 3'd2,
        CFG_SHORT_MAX = 3'd3,
        CFG_LONG_MIN  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] release_ticks;
        logic [CFG_W-1:0] short_min_ticks;
        logic [CFG_W-1:0] short_max_ticks;
        logic [CFG_W-1:0] long_min_ticks;
    } t_cfg;

    // one-hot command to a lane, already qualified by the accept
    typedef struct packed {
        logic fall_edge;
        logic tick;
        logic chk_short;
        logic chk_long;
        logic clr_all;
    } t_lane_cmd;

    typedef struct packed {
        logic short_ev;
        logic long_ev;
        logic flag;
    } t_lane_res;

endpackage

`default_nettype wire

### rtl/bpc_lane.sv
// ---------------------------------------------------------------------------
// bpc_lane
// per-button debounce, release tracking and short/long press detection
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_top_macros.svh"

module bpc_lane
    import bpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire t_lane_cmd        i_cmd,
    input  wire logic             i_pin,
    input  wire logic [MS_W-1:0]  i_now,
    output t_lane_res             o_res
);

    logic             r_armed, n_armed;
    logic             r_released, n_released;
    logic             r_long_rep, n_long_rep;
    logic [CNT_W-1:0] r_high_cnt, n_high_cnt;
    logic [CNT_W-1:0] r_low_cnt, n_low_cnt;
    logic [MS_W-1:0]  r_last_ms, n_last_ms;
    logic             r_short_flag, n_short_flag;
    logic             r_long_flag, n_long_flag;

    logic             w_hi_over;
    logic             w_rel1;
    logic [CNT_W-1:0] w_high1;
    logic             w_lr1;
    logic             w_rel2;
    logic             w_short;
    logic [CNT_W-1:0] w_low2;
    logic             w_long;
    logic [MS_W-1:0]  w_elapsed;
    logic             w_edge_ok;

    // tick evaluation, in the order the press logic requires
    always_comb begin
        w_hi_over = r_high_cnt > i_cfg.release_ticks;
        w_rel1    = r_released | w_hi_over;
        w_high1   = w_hi_over ? '0 : r_high_cnt;
        w_lr1     = w_hi_over ? 1'b0 : r_long_rep;
        w_rel2    = w_rel1 & ~r_armed;
        w_short   = w_rel2 && (r_low_cnt >= i_cfg.short_min_ticks)
                           && (r_low_cnt < i_cfg.short_max_ticks);
        w_low2    = w_rel2 ? '0 : r_low_cnt;
        w_long    = (w_low2 >= i_cfg.long_min_ticks) && !w_lr1;
    end

    assign w_elapsed = i_now - r_last_ms;
    assign w_edge_ok = (w_elapsed > {{(MS_W-CFG_W){1'b0}}, i_cfg.debounce_ms}) && r_released;

    always_comb begin
        n_armed      = r_armed;
        n_released   = r_released;
        n_long_rep   = r_long_rep;
        n_high_cnt   = r_high_cnt;
        n_low_cnt    = r_low_cnt;
        n_last_ms    = r_last_ms;
        n_short_flag = r_short_flag;
        n_long_flag  = r_long_flag;
        if (i_cmd.fall_edge) begin
            if (w_edge_ok) begin
                n_armed   = 1'b1;
                n_last_ms = i_now;
            end
        end else if (i_cmd.tick) begin
            n_armed    = r_armed & ~w_rel1;
            n_released = w_rel2;
            n_long_rep = w_lr1 | w_long;
            n_high_cnt = w_high1;
            n_low_cnt  = w_low2;
            if (!w_rel2) begin
                if (!i_pin) begin
                    n_high_cnt = '0;
                    n_low_cnt  = (w_low2 == '1) ? w_low2 : w_low2 + 1'b1;
                end else begin
                    n_high_cnt = (w_high1 == '1) ? w_high1 : w_high1 + 1'b1;
                end
            end
            if (w_long) begin
                n_long_flag = 1'b1;
            end else if (w_short) begin
                n_short_flag = 1'b1;
            end
        end else if (i_cmd.chk_short) begin
            n_short_flag = 1'b0;
        end else if (i_cmd.chk_long) begin
            n_long_flag = 1'b0;
        end else if (i_cmd.clr_all) begin
            n_short_flag = 1'b0;
            n_long_flag  = 1'b0;
        end
    end

    always_comb begin
        o_res.short_ev = i_cmd.tick & w_short & ~w_long;
        o_res.long_ev  = i_cmd.tick & w_long;
        o_res.flag     = (i_cmd.chk_short & r_short_flag) | (i_cmd.chk_long & r_long_flag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed      <= 1'b0;
            r_released   <= 1'b1;
            r_long_rep   <= 1'b0;
            r_high_cnt   <= '0;
            r_low_cnt    <= '0;
            r_last_ms    <= '0;
            r_short_flag <= 1'b0;
            r_long_flag  <= 1'b0;
        end else begin
            r_armed      <= n_armed;
            r_released   <= n_released;
            r_long_rep   <= n_long_rep;
            r_high_cnt   <= n_high_cnt;
            r_low_cnt    <= n_low_cnt;
            r_last_ms    <= n_last_ms;
            r_short_flag <= n_short_flag;
            r_long_flag  <= n_long_flag;
        end
    end

    `BPC_ASSERT_IMP(a_ev_excl, i_clk, i_rst_n, o_res.long_ev, !o_res.short_ev)
    `BPC_ASSERT_IMP(a_ev_on_tick, i_clk, i_rst_n, o_res.short_ev || o_res.long_ev, i_cmd.tick)
    `BPC_ASSERT_NXT(a_long_marks, i_clk, i_rst_n, o_res.long_ev, r_long_rep && r_long_flag)

endmodule

`default_nettype wire

### rtl/bpc_merge.sv
// ---------------------------------------------------------------------------
// bpc_merge
// combines lane results into one result item and holds it for the receiver
// ---------------------------------------------------------------------------
`default_nettype none

`include "button_press_classifier_top_macros.svh"

module bpc_merge
    import bpc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  wire t_lane_res [BUTTON_COUNT-1:0] i_res,
    output logic                         o_ready,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [M_DATA_W-1:0]          o_m_tdata
);

    logic                r_valid, n_valid;
    logic [M_DATA_W-1:0] r_data;
    logic [EV_W-1:0]     w_short;
    logic [EV_W-1:0]     w_long;
    logic                w_flag;

    always_comb begin
        w_short = '0;
        w_long  = '0;
        w_flag  = 1'b0;
        for (int i = 0; i < BUTTON_COUNT; i++) begin
            w_short[i] = i_res[i].short_ev;
            w_long[i]  = i_res[i].long_ev;
            w_flag     = w_flag | i_res[i].flag;
        end
    end

    // a new item may enter when the slot is empty or is drained this cycle
    assign o_ready = ~r_valid | i_m_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {{(M_DATA_W-2*EV_W-1){1'b0}}, w_flag, w_long, w_short};
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

    `BPC_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, r_valid && !i_m_tready, !o_ready)
    `BPC_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, i_load, r_valid)
    `BPC_ASSERT_NXT(a_hold_data, i_clk, i_rst_n, r_valid && !i_m_tready, r_valid && $stable(r_data))

endmodule

`default_nettype wire

### rtl/button_press_classifier_top.sv
// ---------------------------------------------------------------------------
// button_press_classifier_top
// short and long press detector for four active-low push buttons
// ---------------------------------------------------------------------------
// Usage:
//   input items arrive on the s channel: tuser carries the opcode, tdata the
//   button index, pin levels and millisecond timestamp. every item yields
//   exactly one result item on the m channel (short events, long events and
//   the sticky flag read by a check).
//   one lane per button evaluates the item in parallel; the merge stage packs
//   the lane results into a single output register.
//   o_m_tvalid rises in the cycle after acceptance. one item is accepted
//   every cycle while the receiver takes results, set by the single output
//   register that sits between the lanes and the m channel.
//   when the receiver stalls, the pending result is held and o_s_tready goes
//   low until it is taken; o_s_tready follows i_m_tready in the same cycle.
//   configuration writes on i_cfg_we take effect at the next clock edge; the
//   user must make them only while the block is idle; it is not enforced.
//   synchronous reset loads the default configuration, marks every button
//   released, clears counters and flags, and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_top
    import bpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // [1:0] button, [5:2] pin_levels, [37:6] now_ms, [39:38] zero
    input  wire logic [S_DATA_W-1:0]  i_s_tdata,
    // [2:0] opcode
    input  wire logic [OP_W-1:0]      i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // [3:0] short_events, [7:4] long_events, [8] flag_was_set, [15:9] zero
    output logic [M_DATA_W-1:0]       o_m_tdata
);

    t_cfg                     r_cfg, n_cfg;
    logic                     w_accept;
    logic [BTN_W-1:0]         w_button;
    logic [PIN_W-1:0]         w_pins;
    logic [MS_W-1:0]          w_now;
    t_lane_cmd                w_cmd;
    t_lane_cmd [BUTTON_COUNT-1:0] w_lane_cmd;
    t_lane_res [BUTTON_COUNT-1:0] w_lane_res;

    assign w_accept = i_s_tvalid & o_s_tready;
    assign w_button = i_s_tdata[BTN_W-1:0];
    assign w_pins   = i_s_tdata[BTN_W+PIN_W-1:BTN_W];
    assign w_now    = i_s_tdata[BTN_W+PIN_W+MS_W-1:BTN_W+PIN_W];

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:  n_cfg.debounce_ms     = i_cfg_wdata;
                CFG_RELEASE:   n_cfg.release_ticks   = i_cfg_wdata;
                CFG_SHORT_MIN: n_cfg.short_min_ticks = i_cfg_wdata;
                CFG_SHORT_MAX: n_cfg.short_max_ticks = i_cfg_wdata;
                CFG_LONG_MIN:  n_cfg.long_min_ticks  = i_cfg_wdata;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
            r_cfg.release_ticks   <= RELEASE_RST;
            r_cfg.short_min_ticks <= SHORT_MIN_RST;
            r_cfg.short_max_ticks <= SHORT_MAX_RST;
            r_cfg.long_min_ticks  <= LONG_MIN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // opcode decode, qualified by the accept
    always_comb begin
        w_cmd = '0;
        if (w_accept) begin
            case (t_opcode'(i_s_tuser))
                OP_EDGE:      w_cmd.fall_edge = 1'b1;
                OP_TICK:      w_cmd.tick      = 1'b1;
                OP_CHK_SHORT: w_cmd.chk_short = 1'b1;
                OP_CHK_LONG:  w_cmd.chk_long  = 1'b1;
                OP_CLR_ALL:   w_cmd.clr_all   = 1'b1;
                default:      w_cmd = '0;
            endcase
        end
    end

    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        logic w_sel;

        assign w_sel = (w_button == BTN_W'(g));

        // edge and check items go to the addressed button only
        always_comb begin
            w_lane_cmd[g]           = w_cmd;
            w_lane_cmd[g].fall_edge = w_cmd.fall_edge & w_sel;
            w_lane_cmd[g].chk_short = w_cmd.chk_short & w_sel;
            w_lane_cmd[g].chk_long  = w_cmd.chk_long & w_sel;
        end

        bpc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_cmd   (w_lane_cmd[g]),
            .i_pin   (w_pins[g]),
            .i_now   (w_now),
            .o_res   (w_lane_res[g])
        );
    end

    bpc_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_res      (w_lane_res),
        .o_ready    (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

### tb/button_press_classifier_checker.sv
// ---------------------------------------------------------------------------
// button_press_classifier_checker
// watches both stream channels and the register port of the classifier,
// keeps its own copy of the button state, predicts one result per accepted
// item and compares every result item field by field, oldest first
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_classifier_checker
    import bpc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    // [1:0] button, [5:2] pin_levels, [37:6] now_ms, [39:38] zero
    input  wire logic [S_DATA_W-1:0]  i_s_tdata,
    // [2:0] opcode
    input  wire logic [OP_W-1:0]      i_s_tuser,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // [3:0] short_events, [7:4] long_events, [8] flag_was_set, [15:9] zero
    input  wire logic [M_DATA_W-1:0]  i_m_tdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_short_seen,
    output int                        o_long_seen
);

    // member order puts short_ev in the lowest bits, as on the m channel
    typedef struct packed {
        logic            flag;
        logic [EV_W-1:0] long_ev;
        logic [EV_W-1:0] short_ev;
    } t_press_result;

    t_press_result expected_results[$];

    t_cfg                    cfg_q;
    logic [BUTTON_COUNT-1:0] armed_q;
    logic [BUTTON_COUNT-1:0] released_q;
    logic [BUTTON_COUNT-1:0] long_rep_q;
    logic [BUTTON_COUNT-1:0] short_flag_q;
    logic [BUTTON_COUNT-1:0] long_flag_q;
    logic [CNT_W-1:0]        high_cnt_q [BUTTON_COUNT];
    logic [CNT_W-1:0]        low_cnt_q  [BUTTON_COUNT];
    logic [MS_W-1:0]         last_fall_q[BUTTON_COUNT];

    int fail_count  = 0;
    int checked     = 0;
    int short_seen  = 0;
    int long_seen   = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_short_seen = 0;
        o_long_seen  = 0;
    end

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic classify_item(
        input  logic [OP_W-1:0]  op,
        input  logic [BTN_W-1:0] btn,
        input  logic [PIN_W-1:0] pins,
        input  logic [MS_W-1:0]  now_ms,
        output t_press_result    res
    );
        logic [MS_W-1:0] elapsed;
        logic            short_hit;
        logic            long_hit;
        res = '0;
        case (op)
            OP_EDGE: begin
                // elapsed time wraps modulo 2^32
                elapsed = now_ms - last_fall_q[btn];
                if (elapsed > MS_W'(cfg_q.debounce_ms) && released_q[btn]) begin
                    armed_q[btn]     = 1'b1;
                    last_fall_q[btn] = now_ms;
                end
            end
            OP_TICK: begin
                for (int i = 0; i < BUTTON_COUNT; i++) begin
                    short_hit = 1'b0;
                    long_hit  = 1'b0;
                    if (high_cnt_q[i] > cfg_q.release_ticks) begin
                        high_cnt_q[i] = '0;
                        released_q[i] = 1'b1;
                        long_rep_q[i] = 1'b0;
                    end
                    if (armed_q[i] && released_q[i]) begin
                        armed_q[i]    = 1'b0;
                        released_q[i] = 1'b0;
                    end
                    if (released_q[i]) begin
                        short_hit = (low_cnt_q[i] >= cfg_q.short_min_ticks) &&
                                    (low_cnt_q[i] <  cfg_q.short_max_ticks);
                        low_cnt_q[i] = '0;
                    end
                    if (low_cnt_q[i] >= cfg_q.long_min_ticks && !long_rep_q[i]) begin
                        long_rep_q[i] = 1'b1;
                        long_hit      = 1'b1;
                    end
                    if (!released_q[i]) begin
                        if (!pins[i]) begin
                            high_cnt_q[i] = '0;
                            low_cnt_q[i]  = count_up(low_cnt_q[i]);
                        end else begin
                            high_cnt_q[i] = count_up(high_cnt_q[i]);
                        end
                    end
                    // a long press on the same tick hides the short one
                    if (long_hit) begin
                        long_flag_q[i]   = 1'b1;
                        res.long_ev[i]   = 1'b1;
                    end else if (short_hit) begin
                        short_flag_q[i]  = 1'b1;
                        res.short_ev[i]  = 1'b1;
                    end
                end
            end
            OP_CHK_SHORT: begin
                res.flag          = short_flag_q[btn];
                short_flag_q[btn] = 1'b0;
            end
            OP_CHK_LONG: begin
                res.flag         = long_flag_q[btn];
                long_flag_q[btn] = 1'b0;
            end
            OP_CLR_ALL: begin
                short_flag_q = '0;
                long_flag_q  = '0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_press_result want;
        t_press_result got;
        if (!i_rst_n) begin
            cfg_q.debounce_ms     = DEBOUNCE_RST;
            cfg_q.release_ticks   = RELEASE_RST;
            cfg_q.short_min_ticks = SHORT_MIN_RST;
            cfg_q.short_max_ticks = SHORT_MAX_RST;
            cfg_q.long_min_ticks  = LONG_MIN_RST;
            armed_q      = '0;
            released_q   = '1;
            long_rep_q   = '0;
            short_flag_q = '0;
            long_flag_q  = '0;
            for (int i = 0; i < BUTTON_COUNT; i++) begin
                high_cnt_q[i]  = '0;
                low_cnt_q[i]   = '0;
                last_fall_q[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE:  cfg_q.debounce_ms     = i_cfg_wdata;
                    CFG_RELEASE:   cfg_q.release_ticks   = i_cfg_wdata;
                    CFG_SHORT_MIN: cfg_q.short_min_ticks = i_cfg_wdata;
                    CFG_SHORT_MAX: cfg_q.short_max_ticks = i_cfg_wdata;
                    CFG_LONG_MIN:  cfg_q.long_min_ticks  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_press_result'(i_m_tdata[2*EV_W:0]);
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: tdata %h", i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (got.short_ev !== want.short_ev) begin
                        $error("short_events mismatch: expected %h, actual %h",
                               want.short_ev, got.short_ev);
                        fail_count++;
                    end
                    if (got.long_ev !== want.long_ev) begin
                        $error("long_events mismatch: expected %h, actual %h",
                               want.long_ev, got.long_ev);
                        fail_count++;
                    end
                    if (got.flag !== want.flag) begin
                        $error("flag_was_set mismatch: expected %b, actual %b",
                               want.flag, got.flag);
                        fail_count++;
                    end
                end
                if (i_m_tdata[M_DATA_W-1:2*EV_W+1] !== '0) begin
                    $error("padding mismatch: expected %h, actual %h",
                           {(M_DATA_W-2*EV_W-1){1'b0}}, i_m_tdata[M_DATA_W-1:2*EV_W+1]);
                    fail_count++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                classify_item(i_s_tuser, i_s_tdata[BTN_W-1:0],
                              i_s_tdata[BTN_W+PIN_W-1:BTN_W],
                              i_s_tdata[BTN_W+PIN_W+MS_W-1:BTN_W+PIN_W], want);
                short_seen += $countones(want.short_ev);
                long_seen  += $countones(want.long_ev);
                expected_results.push_back(want);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
        o_short_seen <= short_seen;
        o_long_seen  <= long_seen;
    end

endmodule

`default_nettype wire

### tb/tb_button_press_classifier_top.sv
// ---------------------------------------------------------------------------
// tb_button_press_classifier_top
// stimulus and verdict for the button press classifier
// ---------------------------------------------------------------------------
// a short directed run at the reset settings covers debounce limits, wrap of
// the millisecond clock, a full short press, flag reads and clears and the
// unused opcodes. random phases then drive press sequences (falling edge,
// low ticks, high ticks, checks) mixed with noise under several settings,
// the extremes among them, with bursty input and a stalling receiver. a
// final phase holds a button down and then up for long unbroken tick runs.
// the checker beside the block predicts and compares every result item.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_button_press_classifier_top;
    import bpc_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASE_ITEMS  = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int RUN_TICKS    = 60;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]      s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    int fail_count;
    int results_pending;
    int results_checked;
    int short_seen;
    int long_seen;

    int cycles         = 0;
    int items_sent     = 0;
    int settings_count = 1;
    int burst_left     = 0;
    bit no_gaps        = 1'b0;
    int hold_req       = 0;

    t_cfg            cur_cfg;
    logic [MS_W-1:0] cur_time = '0;

    always #4 clk = ~clk;

    button_press_classifier_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    button_press_classifier_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending),
        .o_checked    (results_checked),
        .o_short_seen (short_seen),
        .o_long_seen  (long_seen)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, results_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: changing stall modes, plus a long hold-off on request
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_period    = 2;
    int rx_phase     = 0;
    int hold_left    = 0;
    int hold_seen    = 0;

    always @(posedge clk) begin : receiver_pattern
        bit ready_next;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(30, 300);
            rx_period    = $urandom_range(2, 4);
        end
        rx_mode_left--;
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            case (rx_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = $urandom_range(0, 1);
                2:       ready_next = (rx_phase % rx_period) == 0;
                default: ready_next = $urandom_range(0, 9) != 0;
            endcase
        end
        m_tready <= ready_next;
    end

    task automatic send_item(
        input logic [OP_W-1:0]  op,
        input logic [BTN_W-1:0] btn,
        input logic [PIN_W-1:0] pins,
        input logic [MS_W-1:0]  now_ms
    );
        if (!no_gaps && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, now_ms, pins, btn};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left > 0) burst_left--;
        items_sent++;
    endtask

    // the checker's count is registered, so look at it only after the next edge
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(CFG_DEBOUNCE,  c.debounce_ms);
        write_reg(CFG_RELEASE,   c.release_ticks);
        write_reg(CFG_SHORT_MIN, c.short_min_ticks);
        write_reg(CFG_SHORT_MAX, c.short_max_ticks);
        write_reg(CFG_LONG_MIN,  c.long_min_ticks);
        cfg_we  <= 1'b0;
        cur_cfg  = c;
        settings_count++;
    endtask

    function automatic t_cfg phase_config(input int phase);
        t_cfg c;
        c.debounce_ms     = CFG_W'($urandom_range(0, 20));
        c.release_ticks   = CFG_W'($urandom_range(0, 4));
        c.short_min_ticks = CFG_W'($urandom_range(0, 4));
        c.short_max_ticks = CFG_W'($urandom_range(0, 12));
        c.long_min_ticks  = CFG_W'($urandom_range(0, 24));
        case (phase)
            2: begin
                c.debounce_ms     = '0;
                c.release_ticks   = '0;
                c.short_min_ticks = '0;
                c.short_max_ticks = '1;
                c.long_min_ticks  = '1;
            end
            4: begin
                c.debounce_ms     = '1;
                c.release_ticks   = 16'd1;
                c.short_min_ticks = 16'd2;
                c.short_max_ticks = 16'd6;
                c.long_min_ticks  = '0;
            end
            6: begin
                // a pressed button never counts as released here
                c.release_ticks   = '1;
                c.short_min_ticks = '0;
                c.short_max_ticks = '0;
                c.long_min_ticks  = 16'd8;
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [MS_W-1:0] pick_delta(input logic [CFG_W-1:0] dbc);
        case ($urandom_range(0, 3))
            0:       return MS_W'($urandom_range(0, dbc));
            1:       return MS_W'(dbc) + 1;
            2:       return MS_W'(dbc) + MS_W'($urandom_range(1, 200));
            default: return $urandom;
        endcase
    endfunction

    // falling edge, low ticks, high ticks that may reach release, then maybe checks
    task automatic press_sequence(input logic [BTN_W-1:0] b);
        int              cap;
        logic [PIN_W-1:0] pins;
        cur_time += pick_delta(cur_cfg.debounce_ms);
        send_item(OP_EDGE, b, PIN_W'($urandom), cur_time);
        if ($urandom_range(0, 3) == 0) begin
            // contact bounce: another edge within the debounce time
            cur_time += MS_W'($urandom_range(0, cur_cfg.debounce_ms));
            send_item(OP_EDGE, b, PIN_W'($urandom), cur_time);
        end
        cap = int'(cur_cfg.short_max_ticks);
        if (int'(cur_cfg.long_min_ticks) > cap) cap = int'(cur_cfg.long_min_ticks);
        cap = (cap > 37) ? 40 : cap + 3;
        repeat ($urandom_range(0, cap)) begin
            pins = PIN_W'($urandom);
            if ($urandom_range(0, 19) != 0) pins[b] = 1'b0;
            send_item(OP_TICK, BTN_W'($urandom), pins, $urandom);
        end
        cap = (int'(cur_cfg.release_ticks) > 9) ? 12 : int'(cur_cfg.release_ticks) + 3;
        repeat ($urandom_range(1, cap)) begin
            pins = PIN_W'($urandom);
            if ($urandom_range(0, 19) != 0) pins[b] = 1'b1;
            send_item(OP_TICK, BTN_W'($urandom), pins, $urandom);
        end
        if ($urandom_range(0, 2) == 0) begin
            send_item(OP_CHK_SHORT, b, PIN_W'($urandom), $urandom);
            send_item(OP_CHK_LONG,  b, PIN_W'($urandom), $urandom);
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        int   phase_start;
        cur_cfg.debounce_ms     = DEBOUNCE_RST;
        cur_cfg.release_ticks   = RELEASE_RST;
        cur_cfg.short_min_ticks = SHORT_MIN_RST;
        cur_cfg.short_max_ticks = SHORT_MAX_RST;
        cur_cfg.long_min_ticks  = LONG_MIN_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: debounce limits at the reset settings
        send_item(OP_EDGE, 2'd0, 4'h0, 32'd0);
        send_item(OP_EDGE, 2'd0, 4'h0, 32'd50);
        send_item(OP_EDGE, 2'd0, 4'h0, 32'd51);
        send_item(OP_EDGE, 2'd3, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_TICK, 2'd0, 4'h0, 32'd0);
        // millisecond wrap, while the button is still held
        send_item(OP_EDGE, 2'd3, 4'h0, 32'h0000_0010);
        send_item(OP_TICK, 2'd3, 4'h0, 32'hFFFF_FFFF);
        // released after more than release_ticks high ticks: short press
        repeat (6) send_item(OP_TICK, 2'd0, 4'hF, 32'd0);
        send_item(OP_CHK_SHORT, 2'd0, 4'h0, 32'd0);
        send_item(OP_CHK_SHORT, 2'd0, 4'h0, 32'd0);
        send_item(OP_CHK_LONG,  2'd3, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_CLR_ALL,   2'd3, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_CHK_SHORT, 2'd3, 4'h0, 32'd0);
        // unused opcodes
        send_item(OP_W'(5), 2'd3, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_W'(6), 2'd1, 4'h5, 32'h5555_5555);
        send_item(OP_W'(7), 2'd0, 4'h0, 32'd0);
        send_item(OP_CHK_SHORT, 2'd1, 4'hA, 32'hAAAA_AAAA);
        send_item(OP_CHK_LONG,  2'd2, 4'h5, 32'd0);
        send_item(OP_EDGE, 2'd2, 4'h0, 32'hFFFF_FFFF);
        send_item(OP_TICK, 2'd1, 4'b1011, 32'd0);
        cur_time = 32'hFFFF_FF00;

        for (int phase = 0; phase < 8; phase++) begin
            if (phase > 0) begin
                wait_for_results();
                apply_config(phase_config(phase));
            end
            // receiver holds off while the sender keeps offering items
            if (phase == 2 || phase == 5) hold_req <= hold_req + 1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                        press_sequence(BTN_W'($urandom));
                    13, 14, 15:
                        send_item(OP_W'($urandom), BTN_W'($urandom), PIN_W'($urandom),
                                  $urandom);
                    16, 17:
                        send_item(OP_CHK_SHORT, BTN_W'($urandom), PIN_W'($urandom),
                                  $urandom);
                    18:
                        send_item(OP_CHK_LONG, BTN_W'($urandom), PIN_W'($urandom),
                                  $urandom);
                    default:
                        send_item(OP_CLR_ALL, BTN_W'($urandom), PIN_W'($urandom),
                                  $urandom);
                endcase
            end
        end

        // hold button 0 down, then up, in unbroken runs of ticks
        wait_for_results();
        c.debounce_ms     = '0;
        c.release_ticks   = '1;
        c.short_min_ticks = '0;
        c.short_max_ticks = '1;
        c.long_min_ticks  = '1;
        apply_config(c);
        no_gaps  = 1'b1;
        cur_time += 1;
        send_item(OP_EDGE, 2'd0, 4'h0, cur_time);
        repeat (RUN_TICKS) send_item(OP_TICK, 2'd0, 4'b1110, 32'd0);
        repeat (RUN_TICKS) send_item(OP_TICK, 2'd0, 4'b1111, 32'd0);
        wait_for_results();
        c.release_ticks = 16'd40;
        apply_config(c);
        repeat (3) send_item(OP_TICK, 2'd0, 4'b1111, 32'd0);
        send_item(OP_CHK_LONG,  2'd0, 4'h0, 32'd0);
        send_item(OP_CHK_SHORT, 2'd0, 4'h0, 32'd0);
        no_gaps = 1'b0;

        wait_for_results();
        repeat (4) @(posedge clk);
        $display("covered %0d items under %0d settings, %0d results compared",
                 items_sent, settings_count, results_checked);
        $display("predicted %0d short and %0d long presses, incl. hold-off and long runs",
                 short_seen, long_seen);
        if (fail_count == 0 && results_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### button_press_classifier_top.f
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_lane.sv
rtl/bpc_merge.sv
rtl/button_press_classifier_top.sv
tb/button_press_classifier_checker.sv
tb/tb_button_press_classifier_top.sv
